// File: hdl/arfd_pkg.sv
// Package: shared types, codes and constants of the frame decoder.
`timescale 1ns / 1ps
`default_nettype none
package arfd_pkg;

    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 1024;

    localparam logic [2:0] KIND_WRITE   = 3'd0;
    localparam logic [2:0] KIND_DONE    = 3'd1;
    localparam logic [2:0] KIND_CORRUPT = 3'd2;
    localparam logic [2:0] KIND_DEPTH   = 3'd3;
    localparam logic [2:0] KIND_SKIPPED = 3'd4;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DEPTH  = 2'd2;

    typedef struct packed {
        logic [7:0] chunk_byte;
        logic       last_byte;
    } t_byte_req;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [20:0] pixel_address;
        logic [4:0]  group_pixels;
        logic [7:0]  repeat_count;
        logic [31:0] group_pattern;
        logic        final_of_step;
    } t_result;

endpackage
`default_nettype wire

// File: hdl/arfd_fifo.sv
// Small request queue between the byte input and the parser.
`timescale 1ns / 1ps
`default_nettype none
module arfd_fifo (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire arfd_pkg::t_byte_req i_data,
    output logic                     o_full,
    output logic                     o_empty,
    input  wire logic                i_pop,
    output arfd_pkg::t_byte_req      o_data
);
    import arfd_pkg::*;

    t_byte_req    r_mem [4];
    logic [1:0]   r_wr;
    logic [1:0]   r_rd;
    logic [2:0]   r_cnt;
    logic         w_do_push;
    logic         w_do_pop;

    assign o_full    = (r_cnt == 3'd4);
    assign o_empty   = (r_cnt == 3'd0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (w_do_pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_cnt <= r_cnt + {2'b00, w_do_push} - {2'b00, w_do_pop};
        end
    end
endmodule
`default_nettype wire

// File: hdl/arfd_parser.sv
// Byte parser: header walk, opcode decode and frame-write command generation.
`timescale 1ns / 1ps
`default_nettype none
module arfd_parser (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_idx,
    input  wire logic [10:0]          i_cfg_data,
    input  wire logic                 i_valid,
    input  wire arfd_pkg::t_byte_req  i_req,
    output logic                      o_v0,
    output arfd_pkg::t_result         o_r0,
    output logic                      o_v1,
    output arfd_pkg::t_result         o_r1,
    input  wire logic                 i_room
);
    import arfd_pkg::*;

    localparam logic [2:0] PH_HEAD      = 3'd0;
    localparam logic [2:0] PH_B1_SKIP   = 3'd1;
    localparam logic [2:0] PH_B1_RLE    = 3'd2;
    localparam logic [2:0] PH_LINE_SKIP = 3'd3;
    localparam logic [2:0] PH_OPCODE    = 3'd4;
    localparam logic [2:0] PH_SKIP2     = 3'd5;
    localparam logic [2:0] PH_DATA      = 3'd6;
    localparam logic [2:0] DSEL_NONE    = 3'd7;

    logic [10:0] r_width, r_height;
    logic [5:0]  r_depth;
    logic [2:0]  r_phase, n_phase;
    logic [3:0]  r_hcnt, n_hcnt;
    logic [15:0] r_hword, n_hword;
    logic [15:0] r_start, n_start;
    logic [16:0] r_lines, n_lines;
    logic signed [23:0] r_row, n_row, r_pix, n_pix;
    logic [9:0]  r_run, n_run;
    logic [31:0] r_shift, n_shift;
    logic [2:0]  r_gidx, n_gidx;
    logic        r_sign, n_sign;
    logic [1:0]  r_fin, n_fin;
    logic [2:0]  r_pend, n_pend;
    logic [2:0]  r_dsel, n_dsel;

    logic signed [23:0] w_area;
    logic [2:0]  w_route;
    logic [4:0]  w_unit;
    logic [2:0]  w_rle_bytes, w_lit_bytes;
    logic [4:0]  w_lit_px;
    logic [7:0]  w_b;
    logic        w_go;
    logic        w_v0, w_v1;
    t_result     w_r0, w_r1;

    assign w_go    = i_valid && i_room;
    assign w_b     = i_req.chunk_byte;
    assign w_area  = 24'(r_width * r_height);

    always_comb begin
        logic [5:0] d;
        d = (r_depth == 6'd16 || r_depth == 6'd24 || r_depth == 6'd32) ? r_depth
            : {1'b0, r_depth[4:0]};
        unique case (d)
            6'd1:    w_route = 3'd0;
            6'd2:    w_route = 3'd1;
            6'd4:    w_route = 3'd2;
            6'd8:    w_route = 3'd3;
            6'd16:   w_route = 3'd4;
            6'd24:   w_route = 3'd5;
            6'd32:   w_route = 3'd6;
            default: w_route = DSEL_NONE;
        endcase
    end

    always_comb begin
        unique case (r_dsel)
            3'd1: begin w_unit = 5'd16; w_rle_bytes = 3'd4; w_lit_bytes = 3'd1; w_lit_px = 5'd4; end
            3'd2: begin w_unit = 5'd8;  w_rle_bytes = 3'd4; w_lit_bytes = 3'd1; w_lit_px = 5'd2; end
            3'd3: begin w_unit = 5'd4;  w_rle_bytes = 3'd4; w_lit_bytes = 3'd4; w_lit_px = 5'd4; end
            3'd4: begin w_unit = 5'd1;  w_rle_bytes = 3'd2; w_lit_bytes = 3'd2; w_lit_px = 5'd1; end
            3'd5: begin w_unit = 5'd1;  w_rle_bytes = 3'd3; w_lit_bytes = 3'd3; w_lit_px = 5'd1; end
            3'd6: begin w_unit = 5'd1;  w_rle_bytes = 3'd4; w_lit_bytes = 3'd4; w_lit_px = 5'd1; end
            default: begin
                w_unit = 5'd16; w_rle_bytes = 3'd2; w_lit_bytes = 3'd1; w_lit_px = 5'd8;
            end
        endcase
    end

    always_comb begin
        logic        conc;
        logic [2:0]  conc_kind;
        logic signed [23:0] p;
        logic signed [23:0] extra;
        logic [7:0]  mag;
        logic        neg;
        logic        do_run;
        logic [4:0]  run_unit;
        logic [4:0]  run_lpx;
        logic [1:0]  lsh;
        logic [2:0]  sel;
        logic [16:0] lines;
        logic [15:0] sl;
        logic        do_begin;
        logic [16:0] lim;
        conc = 1'b0; conc_kind = KIND_WRITE; p = '0; extra = '0;
        mag = '0; neg = 1'b0; do_run = 1'b0; run_unit = w_unit; run_lpx = w_lit_px;
        lsh = '0; sel = '0; lines = '0; sl = '0; do_begin = 1'b0; lim = '0;
        n_phase = r_phase; n_hcnt = r_hcnt; n_hword = r_hword; n_start = r_start;
        n_lines = r_lines; n_row = r_row; n_pix = r_pix; n_run = r_run;
        n_shift = r_shift; n_gidx = r_gidx; n_sign = r_sign; n_fin = r_fin;
        n_pend = r_pend; n_dsel = r_dsel;
        w_v0 = 1'b0; w_v1 = 1'b0; w_r0 = '0; w_r1 = '0;

        if (r_fin != 2'd1 && r_hcnt < 4'd15) begin
            n_hcnt = r_hcnt + 4'd1;
        end
        if (r_fin == 2'd2) begin
            if (n_hcnt >= 4'd8) begin
                w_v0 = 1'b1; w_r0.result_kind = r_pend; n_fin = 2'd1;
            end
        end else if (r_fin == 2'd0) begin
            neg = w_b[7];
            mag = neg ? 8'(~w_b + 8'd1) : w_b;
            unique case (r_phase)
                PH_HEAD: begin
                    unique case (n_hcnt - 4'd1)
                        4'd4, 4'd6, 4'd10: n_hword = {8'd0, w_b};
                        4'd5: begin
                            n_hword = {r_hword[7:0], w_b};
                            if (!n_hword[3]) begin
                                do_begin = 1'b1; sl = '0; lines = {6'd0, r_height};
                            end
                        end
                        4'd7:  n_start = {r_hword[7:0], w_b};
                        4'd11: n_lines = {1'b0, r_hword[7:0], w_b};
                        4'd13: begin
                            lim = 17'({6'd0, r_height}) - 17'(r_start);
                            if ({1'b0, r_height} < {1'b0, r_start}
                                || r_lines > lim) begin
                                conc = 1'b1; conc_kind = KIND_SKIPPED;
                            end else begin
                                do_begin = 1'b1; sl = r_start; lines = r_lines;
                            end
                        end
                        default: ;
                    endcase
                end
                PH_B1_SKIP: begin
                    n_hword = {8'd0, w_b}; n_phase = PH_B1_RLE;
                end
                PH_B1_RLE: begin
                    if (w_b == 8'd0) begin
                        conc = 1'b1; conc_kind = KIND_DONE;
                    end else begin
                        if (r_hword[7]) begin
                            if (r_lines != 0) n_lines = r_lines - 17'd1;
                            n_row = r_row + 24'(r_width);
                            n_pix = n_row + 24'({r_hword[6:0], 4'd0});
                        end else begin
                            n_pix = r_pix + 24'({r_hword[7:0], 4'd0});
                        end
                        if (n_pix < 0 || n_pix > w_area) begin
                            conc = 1'b1; conc_kind = KIND_CORRUPT;
                        end else if (w_b == 8'hff) begin
                            if (n_lines == 0) begin
                                conc = 1'b1; conc_kind = KIND_DONE;
                            end else begin
                                n_phase = PH_B1_SKIP;
                            end
                        end else begin
                            do_run = 1'b1; run_unit = 5'd16; run_lpx = 5'd8;
                        end
                    end
                end
                PH_LINE_SKIP, PH_SKIP2: begin
                    p = (r_phase == PH_LINE_SKIP) ? r_row : r_pix;
                    n_pix = p + 24'(w_unit) * (24'(w_b) - 24'sd1);
                    if (n_pix < 0 || n_pix > w_area) begin
                        conc = 1'b1; conc_kind = KIND_CORRUPT;
                    end else begin
                        n_phase = PH_OPCODE;
                    end
                end
                PH_OPCODE: begin
                    if (w_b == 8'hff) begin
                        n_row = r_row + 24'(r_width);
                        if (r_lines != 0) n_lines = r_lines - 17'd1;
                        if (n_lines == 0) begin
                            conc = 1'b1; conc_kind = KIND_DONE;
                        end else begin
                            n_phase = PH_LINE_SKIP;
                        end
                    end else if (w_b == 8'd0) begin
                        n_phase = PH_SKIP2;
                    end else begin
                        do_run = 1'b1;
                    end
                end
                PH_DATA: begin
                    n_shift = {r_shift[23:0], w_b};
                    n_gidx = r_gidx + 3'd1;
                    if (r_sign) begin
                        if (n_gidx >= w_rle_bytes) begin
                            w_v0 = 1'b1;
                            w_r0.pixel_address = 21'(r_pix);
                            w_r0.group_pixels = w_unit;
                            w_r0.repeat_count = 8'(r_run);
                            w_r0.group_pattern = n_shift;
                            n_pix = r_pix + 24'(r_run) * 24'(w_unit);
                            if (r_dsel == 3'd0) begin
                                if (r_lines == 0) begin
                                    conc = 1'b1; conc_kind = KIND_DONE;
                                end else n_phase = PH_B1_SKIP;
                            end else n_phase = PH_OPCODE;
                        end
                    end else if (n_gidx >= w_lit_bytes) begin
                        w_v0 = 1'b1;
                        w_r0.pixel_address = 21'(r_pix);
                        w_r0.group_pixels = w_lit_px;
                        w_r0.repeat_count = 8'd1;
                        w_r0.group_pattern = n_shift;
                        n_pix = r_pix + 24'(w_lit_px);
                        n_shift = '0; n_gidx = '0;
                        if (r_run != 0) n_run = r_run - 10'd1;
                        if (n_run == 0) begin
                            if (r_dsel == 3'd0) begin
                                if (r_lines == 0) begin
                                    conc = 1'b1; conc_kind = KIND_DONE;
                                end else n_phase = PH_B1_SKIP;
                            end else n_phase = PH_OPCODE;
                        end
                    end
                end
                default: begin
                    conc = 1'b1; conc_kind = KIND_CORRUPT;
                end
            endcase

            if (do_begin) begin
                sel = w_route;
                n_dsel = sel;
                if (sel == DSEL_NONE) begin
                    conc = 1'b1; conc_kind = KIND_DEPTH;
                end else begin
                    n_row = 24'(sl) * 24'(r_width);
                    if (sel == 3'd0) begin
                        n_row = n_row - 24'(r_width);
                        n_pix = n_row;
                        n_lines = lines + 17'd1;
                        n_phase = PH_B1_SKIP;
                    end else begin
                        n_lines = lines;
                        if (lines == 0) begin
                            conc = 1'b1; conc_kind = KIND_DONE;
                        end else n_phase = PH_LINE_SKIP;
                    end
                end
            end

            if (do_run) begin
                case (run_lpx)
                    5'd8:    lsh = 2'd3;
                    5'd4:    lsh = 2'd2;
                    5'd2:    lsh = 2'd1;
                    default: lsh = 2'd0;
                endcase
                extra = 24'(mag) * 24'(run_unit);
                p = n_pix + extra;
                if (p > w_area) begin
                    conc = 1'b1; conc_kind = KIND_CORRUPT;
                end else begin
                    n_sign = neg;
                    n_run = neg ? 10'(mag) : 10'(extra >> lsh);
                    n_shift = '0; n_gidx = '0; n_phase = PH_DATA;
                end
            end

            if (conc) begin
                if (n_hcnt < 4'd8) begin
                    n_fin = 2'd2; n_pend = conc_kind;
                end else begin
                    w_v1 = 1'b1; w_r1.result_kind = conc_kind; n_fin = 2'd1;
                end
            end
        end

        if (i_req.last_byte) begin
            if (n_fin == 2'd2) begin
                w_v1 = 1'b1; w_r1 = '0; w_r1.result_kind = KIND_SKIPPED;
            end else if (n_fin == 2'd0) begin
                w_v1 = 1'b1; w_r1 = '0;
                w_r1.result_kind = (n_phase == PH_HEAD || n_hcnt < 4'd8)
                                   ? KIND_SKIPPED : KIND_CORRUPT;
            end
            n_phase = PH_HEAD; n_hcnt = '0; n_hword = '0; n_start = '0; n_lines = '0;
            n_row = '0; n_pix = '0; n_run = '0; n_shift = '0; n_gidx = '0;
            n_sign = 1'b0; n_fin = 2'd0; n_pend = '0; n_dsel = '0;
        end
        if (w_v1) w_r1.final_of_step = 1'b1;
        else if (w_v0) w_r0.final_of_step = 1'b1;
    end

    assign o_v0 = w_go && w_v0;
    assign o_v1 = w_go && w_v1;
    assign o_r0 = w_r0;
    assign o_r1 = w_r1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 11'd4; r_height <= 11'd4; r_depth <= 6'd8;
            r_phase <= PH_HEAD; r_hcnt <= '0; r_hword <= '0; r_start <= '0;
            r_lines <= '0; r_row <= '0; r_pix <= '0; r_run <= '0; r_shift <= '0;
            r_gidx <= '0; r_sign <= 1'b0; r_fin <= '0; r_pend <= '0; r_dsel <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WIDTH:  r_width  <= (i_cfg_data > 11'(MaxWidth))
                                            ? 11'(MaxWidth) : i_cfg_data;
                    REG_HEIGHT: r_height <= (i_cfg_data > 11'(MaxHeight))
                                            ? 11'(MaxHeight) : i_cfg_data;
                    REG_DEPTH:  r_depth  <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (w_go) begin
                r_phase <= n_phase; r_hcnt <= n_hcnt; r_hword <= n_hword;
                r_start <= n_start; r_lines <= n_lines; r_row <= n_row;
                r_pix <= n_pix; r_run <= n_run; r_shift <= n_shift;
                r_gidx <= n_gidx; r_sign <= n_sign; r_fin <= n_fin;
                r_pend <= n_pend; r_dsel <= n_dsel;
            end
        end
    end
endmodule
`default_nettype wire

// File: hdl/arfd_back.sv
// Back end: result queue that serialises up to two commands per byte.
`timescale 1ns / 1ps
`default_nettype none
module arfd_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_v0,
    input  wire arfd_pkg::t_result i_r0,
    input  wire logic              i_v1,
    input  wire arfd_pkg::t_result i_r1,
    output logic                   o_room,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output arfd_pkg::t_result      o_res
);
    import arfd_pkg::*;

    localparam int Depth = 8;
    t_result    r_mem [Depth];
    logic [2:0] r_wr, r_rd;
    logic [3:0] r_cnt;
    logic       w_pop;
    logic [1:0] w_n;

    assign o_empty = (r_cnt == 4'd0);
    assign w_pop   = i_pop && !o_empty;
    assign o_res   = r_mem[r_rd];
    assign o_room  = (r_cnt <= 4'(Depth - 2));
    assign w_n     = {1'b0, i_v0} + {1'b0, i_v1};

    always_ff @(posedge i_clk) begin
        if (i_v0) begin
            r_mem[r_wr] <= i_r0;
        end
        if (i_v1) begin
            r_mem[i_v0 ? r_wr + 3'd1 : r_wr] <= i_r1;
        end
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + {1'b0, w_n};
            if (w_pop) r_rd <= r_rd + 3'd1;
            r_cnt <= r_cnt + {2'b00, w_n} - {3'b000, w_pop};
        end
    end
endmodule
`default_nettype wire

// File: hdl/animation_rle_frame_decoder_core.sv
// Top level of the animation RLE frame decoder.
//  Channel | Direction | Handshake
//  bytes   | in        | push / full
//  results | out       | empty / pop
//  config  | in        | cfg_we, one write per cycle
// One chunk byte is taken per cycle while the result queue has room; each byte yields zero to two results.
// A four-entry input queue separates the byte source from the parser.
// An eight-entry result queue holds commands; the parser stalls only when
// that queue has fewer than two free places.
// Reset is synchronous and active low and returns the parser to the chunk header.
`timescale 1ns / 1ps
`default_nettype none
module animation_rle_frame_decoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_chunk_byte,
    input  wire logic        i_last_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       o_result_kind,
    output logic [20:0]      o_pixel_address,
    output logic [4:0]       o_group_pixels,
    output logic [7:0]       o_repeat_count,
    output logic [31:0]      o_group_pattern,
    output logic             o_final_of_step
);
    import arfd_pkg::*;

    t_byte_req w_in, w_q;
    logic      w_qempty, w_room, w_v0, w_v1;
    t_result   w_r0, w_r1, w_res;

    assign w_in.chunk_byte = i_chunk_byte;
    assign w_in.last_byte  = i_last_byte;

    arfd_fifo u_in (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(w_in),
        .o_full(full), .o_empty(w_qempty), .i_pop(w_room), .o_data(w_q)
    );

    arfd_parser u_parse (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_valid(!w_qempty), .i_req(w_q),
        .o_v0(w_v0), .o_r0(w_r0), .o_v1(w_v1), .o_r1(w_r1), .i_room(w_room)
    );

    arfd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_v0(w_v0), .i_r0(w_r0), .i_v1(w_v1),
        .i_r1(w_r1), .o_room(w_room), .i_pop(pop), .o_empty(empty), .o_res(w_res)
    );

    assign o_result_kind   = w_res.result_kind;
    assign o_pixel_address = w_res.pixel_address;
    assign o_group_pixels  = w_res.group_pixels;
    assign o_repeat_count  = w_res.repeat_count;
    assign o_group_pattern = w_res.group_pattern;
    assign o_final_of_step = w_res.final_of_step;
endmodule
`default_nettype wire

// File: hdl/arfd_checker.sv
// Port checker for the frame decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module arfd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [2:0] o_result_kind,
    input wire logic       o_final_of_step
);
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_result_kind <= 3'd4) else $error("bad result kind");
    a_status_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result_kind != 3'd0) |-> o_final_of_step)
        else $error("status not final");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty) else $error("results after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty) else $error("result dropped");
endmodule

bind animation_rle_frame_decoder_core arfd_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .empty(empty),
    .pop(pop), .o_result_kind(o_result_kind), .o_final_of_step(o_final_of_step)
);
`default_nettype wire
